[src/glyph_run_span_renderer_core_defines.svh]
// Assertion macros shared by the glyph run span renderer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef GLYPH_RUN_SPAN_RENDERER_CORE_DEFINES_SVH
`define GLYPH_RUN_SPAN_RENDERER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSR_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("glyph renderer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSR_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("glyph renderer check failed");

`endif

[src/gsr_pkg.sv]
// Package for the glyph run span renderer: font layout constants, codes,
// state types and the structs passed between the sequencer and its neighbors.
package gsr_pkg;

    localparam int FONT_BYTES    = 4096;
    localparam int FONT_AW       = 12;
    localparam int FIRST_CODE    = 32;
    localparam int GLYPH_COUNT   = 59;
    localparam int ENTRY_BYTES   = 6;
    localparam int RUNS_BASE     = 354;
    localparam int RUN_BYTES     = 3;

    localparam logic [7:0] MISSING_MARK  = 8'hff;
    localparam logic [7:0] FALLBACK_CODE = 8'h3f;
    localparam logic [7:0] LOWER_A       = 8'h61;
    localparam logic [7:0] LOWER_Z       = 8'h7a;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // Byte offsets inside a glyph entry.
    localparam int ENT_ADVANCE = 0;
    localparam int ENT_XOFF    = 1;
    localparam int ENT_YOFF    = 2;
    localparam int ENT_COUNT   = 3;
    localparam int ENT_IDX_LO  = 4;
    localparam int ENT_IDX_HI  = 5;

    // Byte offsets inside a run.
    localparam int RUN_DX  = 0;
    localparam int RUN_DY  = 1;
    localparam int RUN_LEN = 2;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_MEASURE = 2'd1,
        OP_BEGIN   = 2'd2,
        OP_DRAW    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SETUP,
        ST_EMIT,
        ST_MEAS_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ENTRY,
        PH_RUN
    } phase_t;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         wdata;
    } mem_req_t;

    typedef struct packed {
        logic [15:0] span_x;
        logic [15:0] span_y;
        logic [7:0]  span_length;
        logic [15:0] text_width;
        logic        is_last;
        logic        runs_truncated;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

    // Byte address of the glyph entry for an in-range code.
    function automatic logic [FONT_AW-1:0] entry_base(input logic [7:0] code);
        logic [7:0] idx;
        idx = code - 8'(FIRST_CODE);
        return FONT_AW'(int'(idx) * ENTRY_BYTES);
    endfunction

    localparam logic [FONT_AW-1:0] FALLBACK_BASE =
        FONT_AW'((int'(FALLBACK_CODE) - FIRST_CODE) * ENTRY_BYTES);

endpackage

[src/gsr_font_mem.sv]
// Font byte memory: single port, with a registered synchronous read.
// Depends on gsr_pkg for the memory geometry and the request struct.
module gsr_font_mem
(
    input  logic              clk,
    input  gsr_pkg::mem_req_t req,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [gsr_pkg::FONT_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rd_data_reg <= mem[req.addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/gsr_out_stage.sv]
// Result register between the sequencer and the output stream.
// Depends on gsr_pkg for the result and push structs.
module gsr_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  gsr_pkg::push_t    push,
    output logic              free,
    output logic              valid,
    input  logic              ready,
    output gsr_pkg::result_t  result
);

    logic             valid_reg;
    logic             valid_next;
    gsr_pkg::result_t data_reg;

    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push.valid)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            data_reg <= push.data;
        end
    end

    assign valid  = valid_reg;
    assign result = data_reg;

endmodule

[src/gsr_seq.sv]
// Sequencer: decodes transactions, reads glyph entries and runs from the font
// memory, keeps pen and width state. Depends on gsr_pkg and the macro header.
`include "glyph_run_span_renderer_core_defines.svh"

module gsr_seq
#(
    parameter int MAX_RUNS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [11:0]        font_address,
    input  logic [7:0]         font_byte,
    input  logic [7:0]         char_code,
    input  logic [15:0]        start_x,
    input  logic [15:0]        baseline_y,
    input  logic               right_align,
    output gsr_pkg::mem_req_t  mem_req,
    input  logic [7:0]         rd_data,
    input  logic               out_free,
    output gsr_pkg::push_t     push
);

    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam int AW    = gsr_pkg::FONT_AW;

    gsr_pkg::state_t state_reg, state_next;
    gsr_pkg::phase_t phase_reg, phase_next;

    logic             is_draw_reg, is_draw_next;
    logic [AW-1:0]    entry_base_reg, entry_base_next;
    logic [AW-1:0]    fetch_base_reg, fetch_base_next;
    logic [2:0]       fetch_len_reg, fetch_len_next;
    logic [2:0]       fetch_cnt_reg, fetch_cnt_next;
    logic [7:0]       byte_buf_reg [gsr_pkg::ENTRY_BYTES];
    logic [7:0]       byte_buf_next [gsr_pkg::ENTRY_BYTES];
    logic [15:0]      pen_x_reg, pen_x_next;
    logic [15:0]      pen_y_reg, pen_y_next;
    logic [15:0]      width_reg, width_next;
    logic [15:0]      gx_reg, gx_next;
    logic [15:0]      gy_reg, gy_next;
    logic [AW-1:0]    run_addr_reg, run_addr_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             trunc_reg, trunc_next;

    logic             accept;
    logic [7:0]       folded;
    logic             in_range;
    logic [AW-1:0]    glyph_base;
    logic             count_over;
    logic [CNT_W-1:0] count_clamp;
    logic [AW-1:0]    run_start;
    logic [16:0]      width_sum;
    logic [15:0]      width_sat;
    logic [2:0]       entry_len;
    logic             fetch_done;

    assign in_ready   = (state_reg == gsr_pkg::ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign fetch_done = (fetch_cnt_reg == fetch_len_reg);
    // A measure only needs the advance byte of the entry.
    assign entry_len  = is_draw_reg ? 3'(gsr_pkg::ENTRY_BYTES) : 3'd1;

    // Lower case folds to upper case, then the code is checked against the table.
    always_comb
    begin
        folded = char_code;
        if (char_code >= gsr_pkg::LOWER_A && char_code <= gsr_pkg::LOWER_Z)
        begin
            folded = char_code - gsr_pkg::CASE_OFFSET;
        end
        in_range   = ({1'b0, folded} >= 9'(gsr_pkg::FIRST_CODE)) &&
                     ({1'b0, folded} < 9'(gsr_pkg::FIRST_CODE + gsr_pkg::GLYPH_COUNT));
        glyph_base = gsr_pkg::entry_base(folded);
    end

    always_comb
    begin
        count_over  = byte_buf_reg[gsr_pkg::ENT_COUNT] > 8'(MAX_RUNS);
        count_clamp = count_over ? CNT_W'(MAX_RUNS)
                                 : CNT_W'(byte_buf_reg[gsr_pkg::ENT_COUNT]);
        // Only the low address bits matter since reads wrap around the font.
        run_start   = AW'(gsr_pkg::RUNS_BASE)
                    + {byte_buf_reg[gsr_pkg::ENT_IDX_HI][AW-10:0],
                       byte_buf_reg[gsr_pkg::ENT_IDX_LO], 1'b0}
                    + {byte_buf_reg[gsr_pkg::ENT_IDX_HI][AW-9:0],
                       byte_buf_reg[gsr_pkg::ENT_IDX_LO]};
        width_sum   = {1'b0, width_reg} + {9'd0, byte_buf_reg[gsr_pkg::ENT_ADVANCE]};
        width_sat   = width_sum[16] ? 16'hffff : width_sum[15:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gsr_pkg::ST_IDLE:
            begin
                if (accept && (opcode == gsr_pkg::OP_MEASURE || opcode == gsr_pkg::OP_DRAW))
                begin
                    state_next = gsr_pkg::ST_FETCH;
                end
            end
            gsr_pkg::ST_FETCH:
            begin
                if (fetch_done)
                begin
                    case (phase_reg)
                        gsr_pkg::PH_MARK:  state_next = gsr_pkg::ST_FETCH;
                        gsr_pkg::PH_ENTRY: state_next = gsr_pkg::ST_SETUP;
                        default:           state_next = gsr_pkg::ST_EMIT;
                    endcase
                end
            end
            gsr_pkg::ST_SETUP:
            begin
                if (!is_draw_reg)
                begin
                    state_next = gsr_pkg::ST_MEAS_OUT;
                end
                else if (count_clamp == '0)
                begin
                    state_next = gsr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = gsr_pkg::ST_FETCH;
                end
            end
            gsr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (remain_reg == CNT_W'(1)) ? gsr_pkg::ST_IDLE
                                                           : gsr_pkg::ST_FETCH;
                end
            end
            gsr_pkg::ST_MEAS_OUT:
            begin
                if (out_free)
                begin
                    state_next = gsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsr_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath registers.
    always_comb
    begin
        phase_next      = phase_reg;
        is_draw_next    = is_draw_reg;
        entry_base_next = entry_base_reg;
        fetch_base_next = fetch_base_reg;
        fetch_len_next  = fetch_len_reg;
        fetch_cnt_next  = fetch_cnt_reg;
        byte_buf_next   = byte_buf_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        width_next      = width_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        run_addr_next   = run_addr_reg;
        remain_next     = remain_reg;
        trunc_next      = trunc_reg;

        case (state_reg)
            gsr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        gsr_pkg::OP_BEGIN:
                        begin
                            pen_x_next = right_align ? start_x - width_reg : start_x;
                            pen_y_next = baseline_y;
                            width_next = '0;
                        end
                        gsr_pkg::OP_MEASURE, gsr_pkg::OP_DRAW:
                        begin
                            is_draw_next   = (opcode == gsr_pkg::OP_DRAW);
                            fetch_cnt_next = '0;
                            if (in_range)
                            begin
                                // Check the missing mark before reading the entry.
                                entry_base_next = glyph_base;
                                fetch_base_next = glyph_base + AW'(gsr_pkg::ENT_COUNT);
                                fetch_len_next  = 3'd1;
                                phase_next      = gsr_pkg::PH_MARK;
                            end
                            else
                            begin
                                fetch_base_next = gsr_pkg::FALLBACK_BASE;
                                fetch_len_next  = (opcode == gsr_pkg::OP_DRAW)
                                                ? 3'(gsr_pkg::ENTRY_BYTES) : 3'd1;
                                phase_next      = gsr_pkg::PH_ENTRY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            gsr_pkg::ST_FETCH:
            begin
                if (fetch_cnt_reg != '0)
                begin
                    byte_buf_next[fetch_cnt_reg - 3'd1] = rd_data;
                end
                if (!fetch_done)
                begin
                    fetch_cnt_next = fetch_cnt_reg + 3'd1;
                end
                else if (phase_reg == gsr_pkg::PH_MARK)
                begin
                    fetch_base_next = (rd_data == gsr_pkg::MISSING_MARK)
                                    ? gsr_pkg::FALLBACK_BASE : entry_base_reg;
                    fetch_len_next  = entry_len;
                    fetch_cnt_next  = '0;
                    phase_next      = gsr_pkg::PH_ENTRY;
                end
            end
            gsr_pkg::ST_SETUP:
            begin
                if (is_draw_reg)
                begin
                    gx_next = pen_x_reg + {{8{byte_buf_reg[gsr_pkg::ENT_XOFF][7]}},
                                           byte_buf_reg[gsr_pkg::ENT_XOFF]};
                    gy_next = pen_y_reg - {8'd0, byte_buf_reg[gsr_pkg::ENT_YOFF]};
                    pen_x_next      = pen_x_reg + {8'd0, byte_buf_reg[gsr_pkg::ENT_ADVANCE]};
                    remain_next     = count_clamp;
                    trunc_next      = count_over;
                    run_addr_next   = run_start;
                    fetch_base_next = run_start;
                    fetch_len_next  = 3'(gsr_pkg::RUN_BYTES);
                    fetch_cnt_next  = '0;
                    phase_next      = gsr_pkg::PH_RUN;
                end
            end
            gsr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    remain_next     = remain_reg - CNT_W'(1);
                    run_addr_next   = run_addr_reg + AW'(gsr_pkg::RUN_BYTES);
                    fetch_base_next = run_addr_reg + AW'(gsr_pkg::RUN_BYTES);
                    fetch_cnt_next  = '0;
                end
            end
            gsr_pkg::ST_MEAS_OUT:
            begin
                if (out_free)
                begin
                    width_next = width_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Outputs: memory request and result push.
    always_comb
    begin
        mem_req = '0;
        push    = '0;
        unique case (state_reg)
            gsr_pkg::ST_IDLE:
            begin
                if (accept && opcode == gsr_pkg::OP_WRITE)
                begin
                    mem_req.en    = 1'b1;
                    mem_req.we    = 1'b1;
                    mem_req.addr  = font_address;
                    mem_req.wdata = font_byte;
                end
            end
            gsr_pkg::ST_FETCH:
            begin
                if (!fetch_done)
                begin
                    mem_req.en   = 1'b1;
                    mem_req.addr = fetch_base_reg + AW'(fetch_cnt_reg);
                end
            end
            gsr_pkg::ST_EMIT:
            begin
                push.valid               = out_free;
                push.data.span_x         = gx_reg + {8'd0, byte_buf_reg[gsr_pkg::RUN_DX]};
                push.data.span_y         = gy_reg + {8'd0, byte_buf_reg[gsr_pkg::RUN_DY]};
                push.data.span_length    = byte_buf_reg[gsr_pkg::RUN_LEN];
                push.data.is_last        = (remain_reg == CNT_W'(1));
                push.data.runs_truncated = trunc_reg;
            end
            gsr_pkg::ST_MEAS_OUT:
            begin
                push.valid           = out_free;
                push.data.text_width = width_sat;
                push.data.is_last    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsr_pkg::ST_IDLE;
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            width_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            width_reg <= width_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg      <= phase_next;
        is_draw_reg    <= is_draw_next;
        entry_base_reg <= entry_base_next;
        fetch_base_reg <= fetch_base_next;
        fetch_len_reg  <= fetch_len_next;
        fetch_cnt_reg  <= fetch_cnt_next;
        byte_buf_reg   <= byte_buf_next;
        gx_reg         <= gx_next;
        gy_reg         <= gy_next;
        run_addr_reg   <= run_addr_next;
        remain_reg     <= remain_next;
        trunc_reg      <= trunc_next;
    end

    `GSR_ASSERT_NOW(a_fetch_bound, clk, rst_n, state_reg == gsr_pkg::ST_FETCH, fetch_cnt_reg <= fetch_len_reg)
    `GSR_ASSERT_NOW(a_emit_has_run, clk, rst_n, state_reg == gsr_pkg::ST_EMIT, remain_reg != '0)
    `GSR_ASSERT_NOW(a_push_when_free, clk, rst_n, push.valid, out_free)
    `GSR_ASSERT_NEXT(a_write_one_cycle, clk, rst_n, mem_req.we, state_reg == gsr_pkg::ST_IDLE)

endmodule

[src/glyph_run_span_renderer_core.sv]
// Top level of the glyph run span renderer: stream ports, field unpacking and
// the sequencer, font memory and result register. Depends on gsr_pkg.
//
//   channel   | direction | tdata / tuser contents
//   ----------+-----------+------------------------------------------------
//   s_axis    | in        | font write, measure, begin line, draw char
//   m_axis    | out       | one span per run, or the width after a measure
//
// A write or begin-line transaction is handled in the idle state itself. Each
// entry byte and run byte is a separate read of the single-port font memory,
// whose read is registered. A code outside the table skips the missing-mark
// read.
// Reset clears the pen, baseline and width sum; the font memory is not cleared
// and must be written before it is read.
// The result register lets a span wait while the next run is fetched; the
// sequencer stalls in place while that register is full and not being read.
module glyph_run_span_renderer_core
#(
    parameter int MAX_RUNS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] font_address, [19:12] font_byte, [27:20] char_code,
    // [43:28] start_x, [59:44] baseline_y, [60] right_align, [63:61] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] span_x, [31:16] span_y, [39:32] span_length, [55:40] text_width
    output logic [55:0] m_axis_tdata,
    // is_last
    output logic        m_axis_tlast,
    // [0] runs_truncated
    output logic [0:0]  m_axis_tuser
);

    gsr_pkg::mem_req_t mem_req;
    logic [7:0]        rd_data;
    logic              out_free;
    gsr_pkg::push_t    push;
    gsr_pkg::result_t  result;

    // The sequencer owns all font memory traffic, so a write and a read never
    // overlap on the same entry; a write is done before the next item reads.
    gsr_seq
    #(
        .MAX_RUNS (MAX_RUNS)
    )
    u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .opcode       (s_axis_tuser),
        .font_address (s_axis_tdata[11:0]),
        .font_byte    (s_axis_tdata[19:12]),
        .char_code    (s_axis_tdata[27:20]),
        .start_x      (s_axis_tdata[43:28]),
        .baseline_y   (s_axis_tdata[59:44]),
        .right_align  (s_axis_tdata[60]),
        .mem_req      (mem_req),
        .rd_data      (rd_data),
        .out_free     (out_free),
        .push         (push)
    );

    gsr_font_mem u_font_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    gsr_out_stage u_out_stage
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .free   (out_free),
        .valid  (m_axis_tvalid),
        .ready  (m_axis_tready),
        .result (result)
    );

    assign m_axis_tdata = {result.text_width, result.span_length,
                           result.span_y, result.span_x};
    assign m_axis_tlast = result.is_last;
    assign m_axis_tuser = result.runs_truncated;

endmodule

[dv/tb_glyph_run_span_renderer_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for glyph_run_span_renderer_core: loads a whole font image,
// then draws, measures and aligns text while both stream sides stall at random.
// Depends on gsr_pkg and the renderer RTL only.
module tb_glyph_run_span_renderer_core;

    localparam int GLYPH_MAX_RUNS = 64;
    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 400;
    localparam int SAT_MEASURES   = 260;
    localparam int RUN_LIMIT_NS   = 20_000_000;

    // Glyphs that the font image gives a special shape.
    localparam logic [7:0] GLYPH_BLANK   = " ";  // no runs at all
    localparam logic [7:0] GLYPH_MISSING = "X";  // marked missing, falls back to '?'
    localparam logic [7:0] GLYPH_FULL    = "W";  // exactly the run limit
    localparam logic [7:0] GLYPH_OVER    = "Q";  // one run past the limit
    localparam logic [7:0] GLYPH_HEAVY   = "M";  // far past the limit
    localparam logic [7:0] GLYPH_WIDE    = "Z";  // advance raised to the maximum later

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;

    // The scoreboard keeps its own copy of the font memory, pen and width sum,
    // works out every span or width that an accepted transaction must produce,
    // and matches them in order against what the block delivers.
    class glyph_span_tracker;
        logic [7:0]       font_mem [gsr_pkg::FONT_BYTES];
        logic [15:0]      pen_x;
        logic [15:0]      pen_baseline;
        logic [15:0]      width_sum;
        gsr_pkg::result_t pending_spans [$];
        int               faults;
        int               op_seen [4];
        int               results_checked;
        int               clipped_spans;

        function new();
            pen_x = '0;
            pen_baseline = '0;
            width_sum = '0;
            faults = 0;
            results_checked = 0;
            clipped_spans = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
            foreach (font_mem[i]) font_mem[i] = '0;
        endfunction

        // Every read of the font wraps around the memory size.
        function logic [7:0] peek(int unsigned addr);
            return font_mem[addr % gsr_pkg::FONT_BYTES];
        endfunction

        // Lower case folds to upper case; codes outside the table and glyphs
        // marked missing use the '?' entry, which is taken as stored.
        function int unsigned entry_of(logic [7:0] code);
            logic [7:0]  folded;
            int unsigned base;
            folded = code;
            if (folded >= gsr_pkg::LOWER_A && folded <= gsr_pkg::LOWER_Z)
                folded = folded - gsr_pkg::CASE_OFFSET;
            if (int'(folded) >= gsr_pkg::FIRST_CODE &&
                int'(folded) < gsr_pkg::FIRST_CODE + gsr_pkg::GLYPH_COUNT)
            begin
                base = (int'(folded) - gsr_pkg::FIRST_CODE) * gsr_pkg::ENTRY_BYTES;
                if (peek(base + gsr_pkg::ENT_COUNT) != gsr_pkg::MISSING_MARK)
                    return base;
            end
            return (int'(gsr_pkg::FALLBACK_CODE) - gsr_pkg::FIRST_CODE) * gsr_pkg::ENTRY_BYTES;
        endfunction

        function void take_command(gsr_pkg::op_t op, logic [63:0] cmd);
            logic [11:0]      addr;
            logic [7:0]       data;
            logic [7:0]       code;
            logic [15:0]      sx;
            logic [15:0]      by;
            logic             right;
            int unsigned      e;
            int unsigned      run_at;
            int unsigned      count;
            int unsigned      i;
            logic [7:0]       adv;
            logic [7:0]       xoff;
            logic [7:0]       yoff;
            logic [15:0]      gx;
            logic [15:0]      gy;
            logic [16:0]      sum;
            logic             clipped;
            gsr_pkg::result_t r;
            addr  = cmd[11:0];
            data  = cmd[19:12];
            code  = cmd[27:20];
            sx    = cmd[43:28];
            by    = cmd[59:44];
            right = cmd[60];
            op_seen[op]++;
            case (op)
                gsr_pkg::OP_WRITE:
                    font_mem[addr] = data;
                gsr_pkg::OP_MEASURE:
                begin
                    e = entry_of(code);
                    sum = {1'b0, width_sum} + {9'd0, peek(e + gsr_pkg::ENT_ADVANCE)};
                    width_sum = sum[16] ? 16'hffff : sum[15:0];
                    r = '0;
                    r.text_width = width_sum;
                    r.is_last = 1'b1;
                    pending_spans.push_back(r);
                end
                gsr_pkg::OP_BEGIN:
                begin
                    pen_x = right ? sx - width_sum : sx;
                    pen_baseline = by;
                    width_sum = '0;
                end
                default:
                begin
                    e = entry_of(code);
                    adv  = peek(e + gsr_pkg::ENT_ADVANCE);
                    xoff = peek(e + gsr_pkg::ENT_XOFF);
                    yoff = peek(e + gsr_pkg::ENT_YOFF);
                    count = peek(e + gsr_pkg::ENT_COUNT);
                    run_at = gsr_pkg::RUNS_BASE + gsr_pkg::RUN_BYTES *
                             {peek(e + gsr_pkg::ENT_IDX_HI), peek(e + gsr_pkg::ENT_IDX_LO)};
                    // The x offset is signed, the y offset lifts the glyph above the baseline.
                    gx = pen_x + {{8{xoff[7]}}, xoff};
                    gy = pen_baseline - {8'h00, yoff};
                    clipped = (count > GLYPH_MAX_RUNS);
                    if (clipped)
                        count = GLYPH_MAX_RUNS;
                    for (i = 0; i < count; i++)
                    begin
                        r.span_x = gx + {8'h00, peek(run_at + gsr_pkg::RUN_DX)};
                        r.span_y = gy + {8'h00, peek(run_at + gsr_pkg::RUN_DY)};
                        r.span_length = peek(run_at + gsr_pkg::RUN_LEN);
                        r.text_width = '0;
                        r.is_last = (i == count - 1);
                        r.runs_truncated = clipped;
                        pending_spans.push_back(r);
                        run_at += gsr_pkg::RUN_BYTES;
                    end
                    pen_x = pen_x + {8'h00, adv};
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                faults++;
            end
        endfunction

        function void check_span(gsr_pkg::result_t got);
            gsr_pkg::result_t want;
            if (pending_spans.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual x=%0h y=%0h len=%0h w=%0h",
                         $time, got.span_x, got.span_y, got.span_length, got.text_width);
                faults++;
                return;
            end
            want = pending_spans.pop_front();
            results_checked++;
            if (want.runs_truncated)
                clipped_spans++;
            check_field("span_x", want.span_x, got.span_x);
            check_field("span_y", want.span_y, got.span_y);
            check_field("span_length", 16'(want.span_length), 16'(got.span_length));
            check_field("text_width", want.text_width, got.text_width);
            check_field("is_last", 16'(want.is_last), 16'(got.is_last));
            check_field("runs_truncated", 16'(want.runs_truncated), 16'(got.runs_truncated));
        endfunction
    endclass

    glyph_span_tracker tracker;
    int unsigned       sent = 0;
    int                in_left = 0;
    bit                in_idle = 1'b0;
    int                out_left = 0;
    bit                out_idle = 1'b0;

    glyph_run_span_renderer_core
    #(
        .MAX_RUNS(GLYPH_MAX_RUNS)
    )
    uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Idling comes in stretches: a stretch either draws a fresh idle gap, which may
    // be zero, before every transaction or runs back to back.
    function automatic int pick_gap(inout int left, inout bit idling);
        if (left == 0)
        begin
            left = $urandom_range(8, 48);
            idling = ($urandom_range(0, 2) != 0);
        end
        left--;
        return idling ? int'($urandom_range(0, 19)) : 0;
    endfunction

    function automatic logic [63:0] pack_cmd(logic [11:0] addr, logic [7:0] data,
                                             logic [7:0] code, logic [15:0] sx,
                                             logic [15:0] by, logic right);
        return {3'b000, right, by, sx, code, data, addr};
    endfunction

    function automatic logic [11:0] entry_addr(logic [7:0] code, int offset);
        return 12'((int'(code) - gsr_pkg::FIRST_CODE) * gsr_pkg::ENTRY_BYTES + offset);
    endfunction

    // Run counts stay small most of the time so that long glyphs remain rare.
    function automatic logic [7:0] entry_byte(logic [11:0] addr);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (addr % gsr_pkg::ENTRY_BYTES != gsr_pkg::ENT_COUNT)
            return 8'($urandom);
        if (roll < 7)
            return 8'($urandom_range(0, 8));
        if (roll < 8)
            return gsr_pkg::MISSING_MARK;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] pick_char();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 8'($urandom_range(gsr_pkg::FIRST_CODE,
                                     gsr_pkg::FIRST_CODE + gsr_pkg::GLYPH_COUNT - 1));
        if (roll < 85)
            return 8'($urandom_range(gsr_pkg::LOWER_A, gsr_pkg::LOWER_Z));
        return 8'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // transaction was accepted. Fields that the opcode does not use carry noise.
    task automatic send_item(input gsr_pkg::op_t op, input logic [63:0] payload);
        int gap;
        gap = pick_gap(in_left, in_idle);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = payload;
        s_axis_tuser = op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_command(op, payload);
        sent++;
        @(negedge clk);
    endtask

    task automatic font_write(input logic [11:0] addr, input logic [7:0] data);
        send_item(gsr_pkg::OP_WRITE, pack_cmd(addr, data, 8'($urandom), 16'($urandom),
                                              16'($urandom), 1'($urandom)));
    endtask

    task automatic measure(input logic [7:0] code);
        send_item(gsr_pkg::OP_MEASURE, pack_cmd(12'($urandom), 8'($urandom), code,
                                                16'($urandom), 16'($urandom), 1'($urandom)));
    endtask

    task automatic begin_line(input logic [15:0] sx, input logic [15:0] by, input logic right);
        send_item(gsr_pkg::OP_BEGIN, pack_cmd(12'($urandom), 8'($urandom), 8'($urandom),
                                              sx, by, right));
    endtask

    task automatic draw(input logic [7:0] code);
        send_item(gsr_pkg::OP_DRAW, pack_cmd(12'($urandom), 8'($urandom), code,
                                             16'($urandom), 16'($urandom), 1'($urandom)));
    endtask

    // Every byte of the memory is written before anything reads it, since run
    // indexes may point anywhere once they wrap around the memory.
    task automatic load_font();
        int unsigned a;
        int unsigned code;
        logic [7:0]  value;
        for (a = 0; a < gsr_pkg::FONT_BYTES; a++)
        begin
            code = a / gsr_pkg::ENTRY_BYTES + gsr_pkg::FIRST_CODE;
            if (a >= gsr_pkg::RUNS_BASE)
                value = 8'($urandom);
            else
            begin
                case (a % gsr_pkg::ENTRY_BYTES)
                    gsr_pkg::ENT_ADVANCE:
                        value = 8'($urandom_range(1, 24));
                    gsr_pkg::ENT_COUNT:
                    begin
                        if (code == GLYPH_BLANK)
                            value = 8'd0;
                        else if (code == GLYPH_MISSING)
                            value = gsr_pkg::MISSING_MARK;
                        else if (code == GLYPH_FULL)
                            value = 8'(GLYPH_MAX_RUNS);
                        else if (code == GLYPH_OVER)
                            value = 8'(GLYPH_MAX_RUNS + 1);
                        else if (code == GLYPH_HEAVY)
                            value = 8'd200;
                        else
                            value = 8'($urandom_range(1, 6));
                    end
                    gsr_pkg::ENT_IDX_HI:
                        value = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
                    default:
                        value = 8'($urandom);
                endcase
            end
            font_write(12'(a), value);
        end
    endtask

    // Folding, fallback, run limits, zero runs and coordinate wrap, one by one.
    task automatic directed_cases();
        begin_line(16'h7fff, 16'h8000, 1'b0);
        draw("A");
        draw("a");
        draw("z");
        draw(8'h00);
        draw(8'hff);
        draw("[");
        draw(8'h1f);
        draw(GLYPH_MISSING);
        draw(GLYPH_BLANK);
        draw(GLYPH_FULL);
        draw(GLYPH_OVER);
        draw(GLYPH_HEAVY);
        measure("A");
        measure("m");
        measure(8'h80);
        begin_line(16'h8000, 16'h7fff, 1'b1);
        draw("H");
        // A '?' entry that is itself marked missing is still used as it stands.
        font_write(entry_addr(gsr_pkg::FALLBACK_CODE, gsr_pkg::ENT_COUNT),
                   gsr_pkg::MISSING_MARK);
        draw(GLYPH_MISSING);
        draw(gsr_pkg::FALLBACK_CODE);
        measure(8'h7f);
        font_write(entry_addr(gsr_pkg::FALLBACK_CODE, gsr_pkg::ENT_COUNT), 8'd2);
        begin_line(16'h0000, 16'hffff, 1'b1);
        draw("{");
    endtask

    // Enough maximum advances to pin the width sum at its ceiling, then a
    // right-aligned line that pulls the pen back by the full width.
    task automatic saturate_width();
        int i;
        font_write(entry_addr(GLYPH_WIDE, gsr_pkg::ENT_ADVANCE), 8'hff);
        begin_line(16'h0000, 16'h0000, 1'b0);
        for (i = 0; i < SAT_MEASURES; i++)
            measure((i % 2 == 0) ? GLYPH_WIDE : GLYPH_WIDE + gsr_pkg::CASE_OFFSET);
        begin_line(16'($urandom), 16'($urandom), 1'b1);
        draw(GLYPH_WIDE);
    endtask

    // Mostly whole lines of text: measure the word, start the line (aligned
    // either way) and draw it. The rest is loose transactions and font edits.
    task automatic random_traffic(input int unsigned amount);
        logic [7:0]  word [6];
        logic [11:0] addr;
        int unsigned goal;
        int unsigned n;
        int unsigned i;
        goal = sent + amount;
        while (sent < goal)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                begin
                    word[i] = pick_char();
                    measure(word[i]);
                end
                begin_line(16'($urandom), 16'($urandom), 1'($urandom));
                for (i = 0; i < n; i++)
                    draw(word[i]);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        addr = 12'($urandom_range(0, gsr_pkg::RUNS_BASE - 1));
                        font_write(addr, entry_byte(addr));
                    end
                    1: font_write(12'($urandom), 8'($urandom));
                    2: draw(8'($urandom));
                    3: measure(8'($urandom));
                    default: begin_line(16'($urandom), 16'($urandom), 1'($urandom));
                endcase
            end
        end
    endtask

    // Result side: stall for a drawn number of cycles, then take one
    // transaction and check it against the oldest expectation.
    initial
    begin : result_side
        int               gap;
        gsr_pkg::result_t got;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap(out_left, out_idle);
            if (gap > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got.span_x = m_axis_tdata[15:0];
            got.span_y = m_axis_tdata[31:16];
            got.span_length = m_axis_tdata[39:32];
            got.text_width = m_axis_tdata[55:40];
            got.is_last = m_axis_tlast;
            got.runs_truncated = m_axis_tuser[0];
            tracker.check_span(got);
            @(negedge clk);
        end
    end

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = gsr_pkg::OP_WRITE;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_font();
        directed_cases();
        saturate_width();
        random_traffic(RANDOM_ITEMS);
        s_axis_tvalid = 1'b0;

        // Drain: wait for every expected result, then give a trailing draw
        // without runs time to finish before looking for stray results.
        while (tracker.pending_spans.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d font writes, %0d measures, %0d line starts and %0d draws.",
                 tracker.op_seen[gsr_pkg::OP_WRITE], tracker.op_seen[gsr_pkg::OP_MEASURE],
                 tracker.op_seen[gsr_pkg::OP_BEGIN], tracker.op_seen[gsr_pkg::OP_DRAW]);
        $display("Checked %0d results; %0d were spans of glyphs clipped at %0d runs.",
                 tracker.results_checked, tracker.clipped_spans, GLYPH_MAX_RUNS);
        if (tracker.faults == 0)
        begin
            $display("tb_glyph_run_span_renderer_core: clean");
        end
        else
        begin
            $display("tb_glyph_run_span_renderer_core: errors");
        end
        $finish;
    end

    // Watchdog: the slowest legal run is far shorter than this.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: run did not finish in time", $time);
        $display("tb_glyph_run_span_renderer_core: errors");
        $finish;
    end

endmodule
